/* sv/mavg_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mavg_pkg
// Shared types and constants of the moving average filter.
// ----------------------------------------------------------------------------
package mavg_pkg;

    // width of one sample and of one average
    localparam int SAMPLE_W = 16;

    // divider status seen by the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage : mavg_pkg
`default_nettype wire

/* sv/moving_average_filter.sv */
`timescale 1ns / 1ps
`default_nettype none
// flow: an accepted sample passes ST_UPDATE, ST_DIVIDE and ST_DELIVER before in_ready returns;
//   in ST_DIVIDE the bit-serial divider yields one quotient bit per cycle over the sum width,
//   and ST_DELIVER waits while out_ready holds back the previous result
// reset: rst_n clears sum, fill count, pointer, sequencer and output valid at once;
//   the delay line is not cleared, and its read data is only used once the slot has been written
// ----------------------------------------------------------------------------
// moving_average_filter
// Boxcar moving average over a vector of unsigned samples, with a running sum,
// a delay line in RAM and a shared serial divider.
// ----------------------------------------------------------------------------
module moving_average_filter
    import mavg_pkg::*;
#(
    parameter int WINDOW = 10
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [SAMPLE_W-1:0] sample,
    input  wire logic                last,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic      [SAMPLE_W-1:0] average
);

    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W = $clog2(WINDOW * ((1 << SAMPLE_W) - 1) + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIVIDE,
        ST_DELIVER
    } state_t;

    state_t              state_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [PTR_W-1:0]    ptr_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic                last_reg;
    logic                out_valid_reg;
    logic [SAMPLE_W-1:0] average_reg;

    logic [SUM_W-1:0]    sum_next;
    logic [CNT_W-1:0]    count_next;
    logic [PTR_W-1:0]    ptr_next;
    logic                full;
    logic                accept;
    logic [SAMPLE_W-1:0] oldest;
    div_stat_t           div_stat;
    logic [SUM_W-1:0]    quotient;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE);

    // delay line, oldest slot read on the input beat
    mavg_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW),
        .AW    (PTR_W)
    ) u_ram (
        .clk   (clk),
        .we    (state_reg == ST_UPDATE),
        .waddr (ptr_reg),
        .wdata (sample_reg),
        .re    (accept),
        .raddr (ptr_reg),
        .rdata (oldest)
    );

    // window update
    always_comb
    begin
        full       = (count_reg == CNT_W'(WINDOW));
        sum_next   = sum_reg - (full ? SUM_W'(oldest) : '0) + SUM_W'(sample_reg);
        count_next = full ? count_reg : count_reg + 1'b1;
        ptr_next   = (ptr_reg == PTR_W'(WINDOW - 1)) ? '0 : ptr_reg + 1'b1;
    end

    // shared divider
    mavg_div #(
        .NUM_W (SUM_W),
        .DEN_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == ST_UPDATE),
        .numer    (sum_next),
        .denom    (count_next),
        .stat     (div_stat),
        .quotient (quotient)
    );

    // sequencer, window state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sum_reg       <= '0;
            count_reg     <= '0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= ST_UPDATE;
                    end
                end
                ST_UPDATE:
                begin
                    if (last_reg)
                    begin
                        sum_reg   <= '0;
                        count_reg <= '0;
                        ptr_reg   <= '0;
                    end
                    else
                    begin
                        sum_reg   <= sum_next;
                        count_reg <= count_next;
                        ptr_reg   <= ptr_next;
                    end
                    state_reg <= ST_DIVIDE;
                end
                ST_DIVIDE:
                begin
                    if (div_stat.done)
                    begin
                        state_reg <= ST_DELIVER;
                    end
                end
                ST_DELIVER:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
            // output beat valid: load a new result or drop the taken one
            if (state_reg == ST_DELIVER && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // beat payload capture and result value
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= sample;
            last_reg   <= last;
        end
        if (state_reg == ST_DELIVER && (!out_valid_reg || out_ready))
        begin
            average_reg <= quotient[SAMPLE_W-1:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign average   = average_reg;

    // no new beat while a sample is in flight
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("input accepted while sequencer busy");

    // divider finishes only while the sequencer waits for it
    a_done_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == ST_DIVIDE))
        else $error("divider done outside divide state");

    // divider runs only in the divide state
    a_busy_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> (state_reg == ST_DIVIDE))
        else $error("divider busy outside divide state");

    // fill count and pointer stay in range
    a_window_range: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg <= CNT_W'(WINDOW)) && (ptr_reg <= PTR_W'(WINDOW - 1)))
        else $error("fill count or pointer out of range");

endmodule : moving_average_filter
`default_nettype wire

/* sv/mavg_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mavg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mavg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 10,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule : mavg_ram
`default_nettype wire

/* sv/mavg_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mavg_div
// Restoring shift-subtract divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mavg_div
    import mavg_pkg::*;
#(
    parameter int NUM_W = 20,
    parameter int DEN_W = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] numer,
    input  wire logic [DEN_W-1:0] denom,
    output div_stat_t             stat,
    output logic      [NUM_W-1:0] quotient
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;

    logic [DEN_W:0]   trial;
    logic             fits;
    logic [DEN_W:0]   diff;

    // one trial subtraction
    always_comb
    begin
        trial = {rem_reg, quo_reg[NUM_W-1]};
        fits  = (trial >= {1'b0, den_reg});
        diff  = trial - {1'b0, den_reg};
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath: numerator shifts out the top as quotient bits shift in
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= numer;
            rem_reg <= '0;
            den_reg <= denom;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
            rem_reg <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule : mavg_div
`default_nettype wire

/* sim/mavg_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mavg_checker
// Watches both channels of the moving average filter. Every accepted sample
// beat runs through a boxcar model and queues the average it should produce.
// Every accepted output beat is compared with the oldest queued average.
// ----------------------------------------------------------------------------
module mavg_checker
    import mavg_pkg::*;
#(
    parameter int WINDOW = 10
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic                in_ready,
    input  wire logic [SAMPLE_W-1:0] sample,
    input  wire logic                last,
    input  wire logic                out_valid,
    input  wire logic                out_ready,
    input  wire logic [SAMPLE_W-1:0] average,
    output int                       fail_count,
    output int                       pending
);

    // sum holds a full window of full-scale samples without wrapping
    localparam int SUM_W = $clog2(WINDOW * (2 ** SAMPLE_W));
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int MAX_REPORTS = 10;

    // model state
    logic [SAMPLE_W-1:0] delay_line [WINDOW];
    logic [SUM_W-1:0]    box_sum;
    logic [CNT_W-1:0]    fill;
    logic [PTR_W-1:0]    oldest;

    // averages still owed by the block, oldest first
    logic [SAMPLE_W-1:0] average_q [$];
    int                  mismatches;

    // fold one sample into the window and return the truncated average
    task automatic take_sample(
        input  logic [SAMPLE_W-1:0] s,
        input  logic                ends_vector,
        output logic [SAMPLE_W-1:0] avg
    );
        logic [SUM_W-1:0] quot;
        // full window drops the oldest sample, otherwise the window grows
        if (fill == CNT_W'(WINDOW))
        begin
            box_sum = box_sum - SUM_W'(delay_line[oldest]);
        end
        else
        begin
            fill = fill + 1'b1;
        end
        box_sum = box_sum + SUM_W'(s);
        delay_line[oldest] = s;
        oldest = (oldest == PTR_W'(WINDOW - 1)) ? '0 : oldest + 1'b1;
        quot = box_sum / SUM_W'(fill);
        avg = quot[SAMPLE_W-1:0];
        // end of vector starts a fresh window
        if (ends_vector)
        begin
            box_sum = '0;
            fill = '0;
            oldest = '0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        logic [SAMPLE_W-1:0] want;
        if (!rst_n)
        begin
            box_sum = '0;
            fill = '0;
            oldest = '0;
            average_q.delete();
            mismatches = 0;
        end
        else
        begin
            // output beat against the oldest owed average
            if (out_valid && out_ready)
            begin
                if (average_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: output beat with nothing owed, average %0d",
                                 $realtime, average);
                end
                else
                begin
                    want = average_q.pop_front();
                    if (average !== want)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("%0t: average mismatch, expected %0d, got %0d",
                                     $realtime, want, average);
                    end
                end
            end
            // sample beat adds one owed average
            if (in_valid && in_ready)
            begin
                take_sample(sample, last, want);
                average_q.push_back(want);
            end
        end
        fail_count <= mismatches;
        pending <= average_q.size();
    end

endmodule : mavg_checker
`default_nettype wire

/* sim/tb.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Drives sample vectors into the moving average filter: a short directed set
// of extreme vectors, then random vectors of random length and content, with
// random gaps on the sample side and random stalls on the output side.
// ----------------------------------------------------------------------------
module tb;
    import mavg_pkg::*;

    localparam int WINDOW = 10;
    localparam int RANDOM_BEATS = 1100;
    localparam int TAIL_CYCLES = 40;
    localparam int CYCLE_LIMIT = 400000;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    wire logic           in_ready;
    logic [SAMPLE_W-1:0] sample = '0;
    logic                last = 1'b0;
    wire logic           out_valid;
    logic                out_ready = 1'b0;
    wire logic [SAMPLE_W-1:0] average;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int beats_sent = 0;
    bit tx_burst = 1'b0;

    always #6 clk = ~clk;

    moving_average_filter #(
        .WINDOW(WINDOW)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sample   (sample),
        .last     (last),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .average  (average)
    );

    mavg_checker #(
        .WINDOW(WINDOW)
    ) u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .sample    (sample),
        .last      (last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .average   (average),
        .fail_count(fail_count),
        .pending   (pending)
    );

    // run watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // output side: random stalls, with stretches of steady ready
    initial
    begin
        int stall;
        int run_left;
        bit rx_burst;
        run_left = 0;
        rx_burst = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (run_left == 0)
            begin
                run_left = $urandom_range(5, 40);
                rx_burst = ($urandom_range(0, 3) == 0);
            end
            run_left--;
            stall = rx_burst ? 0 : $urandom_range(0, 7);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            forever
            begin
                @(posedge clk);
                if (out_valid)
                    break;
            end
        end
    end

    // one sample beat, after a random gap
    task automatic push_sample(input logic [SAMPLE_W-1:0] s, input logic ends_vector);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample <= s;
        last <= ends_vector;
        forever
        begin
            @(posedge clk);
            if (in_ready)
                break;
        end
        beats_sent++;
    endtask

    // one vector of random length with a chosen sample pattern
    task automatic push_vector(input int len, input int pattern);
        logic [SAMPLE_W-1:0] s;
        for (int i = 0; i < len; i++)
        begin
            case (pattern)
                1: s = SAMPLE_W'(16'hFFFF - $urandom_range(0, 15));
                2: s = SAMPLE_W'($urandom_range(0, 15));
                3: s = $urandom_range(0, 1) ? '1 : '0;
                default: s = SAMPLE_W'($urandom_range(0, 16'hFFFF));
            endcase
            push_sample(s, i == len - 1);
        end
    endtask

    initial
    begin
        int len;
        int pattern;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single-sample vectors at both extremes
        push_sample('0, 1'b1);
        push_sample('1, 1'b1);
        // full-scale samples past a full window, largest sum
        for (int i = 0; i < WINDOW + 2; i++)
            push_sample('1, i == WINDOW + 1);
        // alternating extremes, exactly one window
        for (int i = 0; i < WINDOW; i++)
            push_sample((i % 2 == 0) ? '0 : '1, i == WINDOW - 1);

        // random vectors, mostly short, some well past the window
        beats_sent = 0;
        while (beats_sent < RANDOM_BEATS)
        begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(1, 25);
            pattern = $urandom_range(0, 5);
            tx_burst = ($urandom_range(0, 3) == 0);
            push_vector(len, pattern);
        end
        in_valid <= 1'b0;

        // drain, then let the block settle
        do
            @(posedge clk);
        while (pending != 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule : tb
`default_nettype wire

/* filelist.f */
sv/mavg_pkg.sv
sv/mavg_ram.sv
sv/mavg_div.sv
sv/moving_average_filter.sv
sim/mavg_checker.sv
sim/tb.sv
